>>> rtl/dvdd_pkg.sv
// ----------------------------------------------------------------------------
// dvdd_pkg
// Shared widths, constants, status codes, lookup functions and pipeline
// stage types for the date check and day difference block.
// ----------------------------------------------------------------------------
package dvdd_pkg;

   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int YEAR_W  = 15;
   localparam int JDN_W   = 23;
   localparam int STAT_W  = 2;

   localparam logic [STAT_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_FIRST_BAD = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_SECOND_BAD = 2'd2;
   localparam logic [STAT_W-1:0] STATUS_FIRST_EARLY = 2'd3;

   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

   localparam int YEAR_MIN       = -4700;
   localparam int YEAR_MAX       = 9999;
   localparam int YEAR_BIAS      = 4800;
   localparam int CENTURY_BIAS   = 4900;
   localparam int DAYS_4_YEARS   = 1461;
   localparam int JDN_BIAS       = 32075;
   localparam int RECIP100       = 5243;
   localparam int RECIP100_SHIFT = 19;
   localparam int HUNDRED        = 100;

   // Offset year y + bias stays below 2**14 for every valid year.
   localparam int YOFF_W = 14;
   localparam int P1_W   = 25;
   localparam int PQ_W   = 27;
   localparam int Q_W    = 8;
   localparam int MT_W   = 9;
   localparam int T3_W   = 8;

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
      logic [DAY_W-1:0] r;
      case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                     r = 5'd30;
         4'd2:                                         r = 5'd28;
         default:                                      r = 5'd0;
      endcase
      return r;
   endfunction

   // Month term of the day count, floor(367 * (m - 2 + 12a) / 12).
   function automatic logic [MT_W-1:0] month_term(input logic [MONTH_W-1:0] m);
      logic [MT_W-1:0] r;
      case (m)
         4'd1:    r = 9'd336;
         4'd2:    r = 9'd367;
         4'd3:    r = 9'd30;
         4'd4:    r = 9'd61;
         4'd5:    r = 9'd91;
         4'd6:    r = 9'd122;
         4'd7:    r = 9'd152;
         4'd8:    r = 9'd183;
         4'd9:    r = 9'd214;
         4'd10:   r = 9'd244;
         4'd11:   r = 9'd275;
         4'd12:   r = 9'd305;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

   typedef struct packed {
      logic              year_ok;
      logic              month_ok;
      logic              is_feb;
      logic              year_zero;
      logic [YOFF_W-1:0] ya;
      logic [YOFF_W-1:0] yb;
      logic [YOFF_W-1:0] yo;
      logic [DAY_W-1:0]  day;
      logic [MT_W-1:0]   mterm;
      logic [DAY_W-1:0]  mlen;
   } dvdd_s1_type;

   typedef struct packed {
      logic              year_ok;
      logic              month_ok;
      logic              is_feb;
      logic              year_zero;
      logic [P1_W-1:0]   p1;
      logic [PQ_W-1:0]   pq;
      logic [PQ_W-1:0]   pr;
      logic [YOFF_W-1:0] yo;
      logic [DAY_W-1:0]  day;
      logic [MT_W-1:0]   mterm;
      logic [DAY_W-1:0]  mlen;
   } dvdd_s2_type;

   typedef struct packed {
      logic             range_ok;
      logic             is_feb;
      logic             leap;
      logic [JDN_W-1:0] part;
      logic [T3_W-1:0]  t3;
      logic [DAY_W-1:0] day;
      logic [DAY_W-1:0] mlen;
   } dvdd_s3_type;

   typedef struct packed {
      logic             ok;
      logic [JDN_W-1:0] jdn;
   } dvdd_s4_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [JDN_W-1:0]  day_difference;
      logic [JDN_W-1:0]  first_jdn;
      logic [JDN_W-1:0]  second_jdn;
      logic              first_earlier;
      logic              dates_equal;
   } dvdd_out_type;

endpackage

>>> rtl/dvdd_if.sv
// ----------------------------------------------------------------------------
// dvdd_req_if / dvdd_rsp_if
// Valid/ready channels carrying one date pair and one comparison result.
// ----------------------------------------------------------------------------
interface dvdd_req_if;
   logic                          valid;
   logic                          ready;
   logic [dvdd_pkg::DAY_W-1:0]    first_day;
   logic [dvdd_pkg::MONTH_W-1:0]  first_month;
   logic signed [dvdd_pkg::YEAR_W-1:0] first_year;
   logic [dvdd_pkg::DAY_W-1:0]    second_day;
   logic [dvdd_pkg::MONTH_W-1:0]  second_month;
   logic signed [dvdd_pkg::YEAR_W-1:0] second_year;

   modport source (output valid, first_day, first_month, first_year,
                   second_day, second_month, second_year, input ready);
   modport sink   (input valid, first_day, first_month, first_year,
                   second_day, second_month, second_year, output ready);
endinterface

interface dvdd_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [dvdd_pkg::STAT_W-1:0]  status;
   logic [dvdd_pkg::JDN_W-1:0]   day_difference;
   logic [dvdd_pkg::JDN_W-1:0]   first_jdn;
   logic [dvdd_pkg::JDN_W-1:0]   second_jdn;
   logic                         first_earlier;
   logic                         dates_equal;

   modport source (output valid, status, day_difference, first_jdn, second_jdn,
                   first_earlier, dates_equal, input ready);
   modport sink   (input valid, status, day_difference, first_jdn, second_jdn,
                   first_earlier, dates_equal, output ready);
endinterface

>>> rtl/date_validate_and_day_difference.sv
// ----------------------------------------------------------------------------
// date_validate_and_day_difference
// Checks two Gregorian dates, converts each to its Julian Day Number and
// reports both numbers, order flags, a status code and the day difference.
//
//   Channel   Direction  Handshake         Contents
//   req_bus   in         valid / ready     two dates: day, month, year each
//   rsp_bus   out        valid / ready     status, difference, two JDNs, flags
//
// One transaction enters per cycle while the response side is not stalled.
// Each of the five stages has its own valid bit and advances whenever it
// is empty or its successor advances, so bubbles close up and a stall on
// the response side holds every stage without loss. Reset clears only the
// valid bits.
// ----------------------------------------------------------------------------
module date_validate_and_day_difference (
   input logic clock,
   input logic reset,
   dvdd_req_if.sink   req_bus,
   dvdd_rsp_if.source rsp_bus
);
   import dvdd_pkg::*;

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic en1, en2, en3, en4, en5;

   dvdd_s1_type  s1_ff [2];
   dvdd_s1_type  s1_in [2];
   dvdd_s2_type  s2_ff [2];
   dvdd_s2_type  s2_in [2];
   dvdd_s3_type  s3_ff [2];
   dvdd_s3_type  s3_in [2];
   dvdd_s4_type  s4_ff [2];
   dvdd_s4_type  s4_in [2];
   dvdd_out_type out_ff;
   dvdd_out_type out_in;
   logic eq1_ff, eq2_ff, eq3_ff, eq4_ff;
   logic eq1_in;

   logic [DAY_W-1:0]   in_day   [2];
   logic [MONTH_W-1:0] in_month [2];
   logic [YEAR_W-1:0]  in_year  [2];

   assign en5 = !v5_ff || rsp_bus.ready;
   assign en4 = !v4_ff || en5;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_bus.ready = en1;

   assign in_day[0]   = req_bus.first_day;
   assign in_month[0] = req_bus.first_month;
   assign in_year[0]  = req_bus.first_year;
   assign in_day[1]   = req_bus.second_day;
   assign in_month[1] = req_bus.second_month;
   assign in_year[1]  = req_bus.second_year;

   assign eq1_in = (req_bus.first_day == req_bus.second_day) &&
                   (req_bus.first_month == req_bus.second_month) &&
                   (req_bus.first_year == req_bus.second_year);

   // Stage 1: range checks, offset years and month tables.
   always_comb begin
      logic signed [YEAR_W-1:0] ys;
      logic [15:0]              y16;
      logic [15:0]              early16;
      logic [15:0]              ya16;
      logic [15:0]              yb16;
      logic [15:0]              yo16;
      for (int i = 0; i < 2; i++) begin
         ys      = signed'(in_year[i]);
         y16     = {in_year[i][YEAR_W-1], in_year[i]};
         early16 = {15'd0, (in_month[i] <= MONTH_FEB)};
         ya16    = y16 + 16'(YEAR_BIAS) - early16;
         yb16    = y16 + 16'(CENTURY_BIAS) - early16;
         yo16    = y16 + 16'(YEAR_BIAS);
         s1_in[i].year_ok   = (ys >= 15'(YEAR_MIN)) && (ys <= 15'(YEAR_MAX));
         s1_in[i].month_ok  = (in_month[i] >= MONTH_JAN) && (in_month[i] <= MONTH_DEC);
         s1_in[i].is_feb    = (in_month[i] == MONTH_FEB);
         s1_in[i].year_zero = (in_year[i] == '0);
         s1_in[i].ya        = ya16[YOFF_W-1:0];
         s1_in[i].yb        = yb16[YOFF_W-1:0];
         s1_in[i].yo        = yo16[YOFF_W-1:0];
         s1_in[i].day       = in_day[i];
         s1_in[i].mterm     = month_term(in_month[i]);
         s1_in[i].mlen      = month_len(in_month[i]);
      end
   end

   // Stage 2: constant multiplications.
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         s2_in[i].year_ok   = s1_ff[i].year_ok;
         s2_in[i].month_ok  = s1_ff[i].month_ok;
         s2_in[i].is_feb    = s1_ff[i].is_feb;
         s2_in[i].year_zero = s1_ff[i].year_zero;
         s2_in[i].p1        = P1_W'(s1_ff[i].ya) * P1_W'(DAYS_4_YEARS);
         s2_in[i].pq        = PQ_W'(s1_ff[i].yb) * PQ_W'(RECIP100);
         s2_in[i].pr        = PQ_W'(s1_ff[i].yo) * PQ_W'(RECIP100);
         s2_in[i].yo        = s1_ff[i].yo;
         s2_in[i].day       = s1_ff[i].day;
         s2_in[i].mterm     = s1_ff[i].mterm;
         s2_in[i].mlen      = s1_ff[i].mlen;
      end
   end

   // Stage 3: partial day count, century term and leap year.
   always_comb begin
      logic [Q_W-1:0]    q;
      logic [Q_W-1:0]    ql;
      logic [9:0]        q3;
      logic [P1_W-1:0]   sum;
      logic [YOFF_W-1:0] rem;
      for (int i = 0; i < 2; i++) begin
         q   = s2_ff[i].pq[RECIP100_SHIFT +: Q_W];
         ql  = s2_ff[i].pr[RECIP100_SHIFT +: Q_W];
         q3  = 10'(q) * 10'd3;
         sum = P1_W'(s2_ff[i].p1[P1_W-1:2]) + P1_W'(s2_ff[i].mterm) +
               P1_W'(s2_ff[i].day) - P1_W'(JDN_BIAS);
         rem = s2_ff[i].yo - (YOFF_W'(ql) * YOFF_W'(HUNDRED));
         s3_in[i].range_ok = s2_ff[i].year_ok && s2_ff[i].month_ok;
         s3_in[i].is_feb   = s2_ff[i].is_feb;
         s3_in[i].leap     = !s2_ff[i].year_zero && (s2_ff[i].yo[1:0] == 2'd0) &&
                             ((rem != '0) || (ql[1:0] == 2'd0));
         s3_in[i].part     = sum[JDN_W-1:0];
         s3_in[i].t3       = q3[9:2];
         s3_in[i].day      = s2_ff[i].day;
         s3_in[i].mlen     = s2_ff[i].mlen;
      end
   end

   // Stage 4: final day number and day check.
   always_comb begin
      logic [DAY_W:0] lim;
      for (int i = 0; i < 2; i++) begin
         lim = {1'b0, s3_ff[i].mlen} + {{DAY_W{1'b0}}, s3_ff[i].is_feb && s3_ff[i].leap};
         s4_in[i].ok  = s3_ff[i].range_ok && (s3_ff[i].day != '0) &&
                        ({1'b0, s3_ff[i].day} <= lim);
         s4_in[i].jdn = s3_ff[i].part - JDN_W'(s3_ff[i].t3);
      end
   end

   // Stage 5: order, status and difference.
   always_comb begin
      logic both_ok;
      logic earlier;
      both_ok = s4_ff[0].ok && s4_ff[1].ok;
      earlier = both_ok && (s4_ff[0].jdn < s4_ff[1].jdn);
      out_in.first_jdn      = s4_ff[0].ok ? s4_ff[0].jdn : '0;
      out_in.second_jdn     = s4_ff[1].ok ? s4_ff[1].jdn : '0;
      out_in.first_earlier  = earlier;
      out_in.dates_equal    = both_ok && eq4_ff;
      out_in.day_difference = '0;
      if (!s4_ff[0].ok) begin
         out_in.status = STATUS_FIRST_BAD;
      end else if (!s4_ff[1].ok) begin
         out_in.status = STATUS_SECOND_BAD;
      end else if (earlier) begin
         out_in.status = STATUS_FIRST_EARLY;
      end else begin
         out_in.status         = STATUS_OK;
         out_in.day_difference = s4_ff[0].jdn - s4_ff[1].jdn;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_bus.valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_ff  <= s1_in;
         eq1_ff <= eq1_in;
      end
      if (en2) begin
         s2_ff  <= s2_in;
         eq2_ff <= eq1_ff;
      end
      if (en3) begin
         s3_ff  <= s3_in;
         eq3_ff <= eq2_ff;
      end
      if (en4) begin
         s4_ff  <= s4_in;
         eq4_ff <= eq3_ff;
      end
      if (en5) begin
         out_ff <= out_in;
      end
   end

   assign rsp_bus.valid          = v5_ff;
   assign rsp_bus.status         = out_ff.status;
   assign rsp_bus.day_difference = out_ff.day_difference;
   assign rsp_bus.first_jdn      = out_ff.first_jdn;
   assign rsp_bus.second_jdn     = out_ff.second_jdn;
   assign rsp_bus.first_earlier  = out_ff.first_earlier;
   assign rsp_bus.dates_equal    = out_ff.dates_equal;

endmodule
